### rtl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared widths, request/status/slot codes and types for the hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

	// fixed payload widths
	localparam int FUNC_W     = 2;
	localparam int KEY_IN_W   = 64;
	localparam int VALUE_IN_W = 32;
	localparam int STATUS_W   = 2;
	localparam int POS_W      = 6;
	localparam int SLOT_W     = 2;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [SLOT_W-1:0]   slot_t;

	// request kinds
	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_DELETE = 2'd1;
	localparam func_t FUNC_LOOKUP = 2'd2;
	localparam func_t FUNC_CLEAR  = 2'd3;

	// result status codes
	localparam status_t STATUS_DONE      = 2'd0;
	localparam status_t STATUS_NOT_FOUND = 2'd1;
	localparam status_t STATUS_FULL      = 2'd2;

	// slot state codes
	localparam slot_t SLOT_EMPTY   = 2'd0;
	localparam slot_t SLOT_USED    = 2'd1;
	localparam slot_t SLOT_DELETED = 2'd2;

endpackage

### rtl/oaht_req_if.sv
// ----------------------------------------------------------------------------
// oaht_req_if
// Request channel: valid/ready handshake carrying func, key and value.
// ----------------------------------------------------------------------------
interface oaht_req_if
	import oaht_pkg::*;
	();

	logic                  valid;
	logic                  ready;
	func_t                 func;
	logic [KEY_IN_W-1:0]   key;
	logic [VALUE_IN_W-1:0] value;

	modport source (output valid, output func, output key, output value, input ready);
	modport sink   (input valid, input func, input key, input value, output ready);

endinterface

### rtl/oaht_rsp_if.sv
// ----------------------------------------------------------------------------
// oaht_rsp_if
// Response channel: valid/ready handshake carrying status and position.
// ----------------------------------------------------------------------------
interface oaht_rsp_if
	import oaht_pkg::*;
	();

	logic             valid;
	logic             ready;
	status_t          status;
	logic [POS_W-1:0] position;

	modport source (output valid, output status, output position, input ready);
	modport sink   (input valid, input status, input position, output ready);

endinterface

### rtl/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/oaht_modadd.sv
// ----------------------------------------------------------------------------
// oaht_modadd
// Shared modular adder: y = (a + b + cin) mod MODULUS for a, b below MODULUS.
// ----------------------------------------------------------------------------
module oaht_modadd #(
	parameter int MODULUS = 64
) (
	input  logic [$clog2(MODULUS)-1:0] a,
	input  logic [$clog2(MODULUS)-1:0] b,
	input  logic                       cin,
	output logic [$clog2(MODULUS)-1:0] y
);

	localparam int W = $clog2(MODULUS);
	localparam logic [W:0] MOD = (W+1)'(MODULUS);

	logic [W:0] raw;
	logic [W:0] reduced;

	// one add and a single conditional subtract, the sum stays below 2*MODULUS
	always_comb begin
		raw     = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, cin};
		reduced = raw - MOD;
		y       = (raw >= MOD) ? reduced[W-1:0] : raw[W-1:0];
	end

endmodule

### rtl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressing hash table with linear or quadratic probing.
//
//   channel   dir  handshake          payload
//   req       in   valid/ready        func, key, value
//   rsp       out  valid/ready        status, position
//   cfg       in   cfg_we             cfg_wdata (probe_mode)
//
// An item passes from ST_HASH through ST_ISSUE and ST_CHECK for each probe to
// ST_RESP: the home slot comes from a reciprocal multiply and then a multiply
// and subtract, each probe is a slot-memory read followed by a check, and the
// shared modular adder steps the probe address. Clear sweeps every slot, one
// slot a cycle, then answers in ST_RESP. After reset a sweep of every slot
// empties the slot memory before req.ready rises.
// A finished result waits in the rsp register while the next item is taken.
// ----------------------------------------------------------------------------
module open_addressing_hash_table
	import oaht_pkg::*;
#(
	parameter int TABLE_SLOTS = 64,
	parameter int KEY_CHARS   = 8,
	parameter int VALUE_BITS  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	oaht_req_if.sink   req,
	oaht_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	localparam int IDX_W  = $clog2(TABLE_SLOTS);
	localparam int KEY_W  = 8 * KEY_CHARS;
	localparam int VAL_W  = (VALUE_BITS < VALUE_IN_W) ? VALUE_BITS : VALUE_IN_W;
	localparam int SUM_W  = $clog2(KEY_CHARS * 255 + 1);
	localparam int RCP_W  = SUM_W + 2;
	localparam int SHIFT  = SUM_W + IDX_W;
	localparam int PROD_W = SHIFT + SUM_W;
	localparam int QP_W   = SUM_W + IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [RCP_W-1:0] RECIP    =
		RCP_W'(((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_HASH  = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;
	localparam logic [2:0] ST_SWEEP = 3'd5;

	logic [2:0]        state_q;
	logic              probe_mode_q;
	func_t             func_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [SUM_W-1:0]  sum_q;
	logic              hash_ph_q;
	logic [SUM_W-1:0]  quot_q;
	logic [IDX_W-1:0]  addr_q;
	logic [IDX_W-1:0]  step_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              reply_q;
	status_t           res_status_q;
	logic [POS_W-1:0]  res_pos_q;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [POS_W-1:0]  rsp_pos_q;

	logic [KEY_W-1:0]  key_norm;
	logic [SUM_W-1:0]  key_sum;
	logic              alive;
	logic [7:0]        kbyte;

	logic [PROD_W-1:0] recip_prod;
	logic [QP_W-1:0]   quot_prod;
	logic [SUM_W-1:0]  home_rem;

	logic [IDX_W-1:0]  alu_a;
	logic [IDX_W-1:0]  alu_b;
	logic              alu_cin;
	logic [IDX_W-1:0]  alu_y;

	slot_t             slot_rd;
	logic [KEY_W-1:0]  key_rd;
	logic              st_we;
	slot_t             st_wdata;
	logic [IDX_W-1:0]  st_waddr;
	logic              kv_we;

	logic              hit;
	logic              rsp_load;
	logic [POS_W+IDX_W-1:0] pos_ext;

	// cut the key at its first zero byte and add up its characters
	always_comb begin
		key_norm = '0;
		key_sum  = '0;
		alive    = 1'b1;
		kbyte    = '0;
		for (int j = 0; j < KEY_CHARS; j++) begin
			kbyte = req.key[8*j +: 8];
			if (kbyte == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				key_norm[8*j +: 8] = kbyte;
				key_sum            = key_sum + SUM_W'(kbyte);
			end
		end
	end

	// home slot: quotient by reciprocal multiply, then sum minus quotient times slots
	assign recip_prod = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign quot_prod  = QP_W'(quot_q) * QP_W'(TABLE_SLOTS);
	assign home_rem   = sum_q - quot_prod[SUM_W-1:0];

	// operand selection for the shared modular adder
	always_comb begin
		alu_a   = addr_q;
		alu_b   = '0;
		alu_cin = 1'b1;
		case (state_q)
			ST_ISSUE: begin
				alu_a   = step_q;
				alu_b   = IDX_W'(1);
				alu_cin = 1'b1;
			end
			ST_CHECK: begin
				alu_a   = addr_q;
				alu_b   = probe_mode_q ? step_q : '0;
				alu_cin = ~probe_mode_q;
			end
			default: begin
				alu_a   = addr_q;
				alu_b   = '0;
				alu_cin = 1'b1;
			end
		endcase
	end

	oaht_modadd #(
		.MODULUS (TABLE_SLOTS)
	) u_modadd (
		.a   (alu_a),
		.b   (alu_b),
		.cin (alu_cin),
		.y   (alu_y)
	);

	// probe check on the slot read back from memory
	always_comb begin
		if (func_q == FUNC_INSERT) begin
			hit = (slot_rd != SLOT_USED);
		end else begin
			hit = (slot_rd == SLOT_USED) && (key_rd == key_q);
		end
	end

	// slot memory write controls
	always_comb begin
		st_we    = 1'b0;
		st_wdata = SLOT_EMPTY;
		st_waddr = addr_q;
		kv_we    = 1'b0;
		if (state_q == ST_SWEEP) begin
			st_we    = 1'b1;
			st_waddr = cnt_q;
		end else if (state_q == ST_CHECK && hit) begin
			st_we    = (func_q != FUNC_LOOKUP);
			st_wdata = (func_q == FUNC_INSERT) ? SLOT_USED : SLOT_DELETED;
			kv_we    = (func_q == FUNC_INSERT);
		end
	end

	oaht_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TABLE_SLOTS)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (addr_q),
		.rdata (slot_rd)
	);

	oaht_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (addr_q),
		.wdata (key_q),
		.raddr (addr_q),
		.rdata (key_rd)
	);

	// stored values are kept alongside the keys
	oaht_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_SLOTS)
	) u_value_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (addr_q),
		.wdata (value_q),
		.raddr (addr_q),
		.rdata ()
	);

	assign pos_ext   = {POS_W'(0), addr_q};
	assign req.ready = (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_mode_q <= 1'b0;
		end else if (cfg_we) begin
			probe_mode_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			cnt_q   <= '0;
			reply_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q   <= '0;
						reply_q <= 1'b1;
						state_q <= (req.func == FUNC_CLEAR) ? ST_SWEEP : ST_HASH;
					end
				end
				ST_HASH: begin
					if (!hash_ph_q) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (hit || cnt_q == LAST_IDX) begin
						state_q <= ST_RESP;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_ISSUE;
					end
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= reply_q ? ST_RESP : ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload, home slot reduction and probe stepping
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q       <= req.func;
				key_q        <= key_norm;
				value_q      <= req.value[VAL_W-1:0];
				sum_q        <= key_sum;
				hash_ph_q    <= 1'b1;
				addr_q       <= '0;
				step_q       <= LAST_IDX;
				res_status_q <= STATUS_DONE;
				res_pos_q    <= '0;
			end
			ST_HASH: begin
				hash_ph_q <= 1'b0;
				if (hash_ph_q) begin
					quot_q <= recip_prod[SHIFT +: SUM_W];
				end else begin
					addr_q <= IDX_W'(home_rem);
				end
			end
			ST_ISSUE: begin
				step_q <= alu_y;
			end
			ST_CHECK: begin
				if (hit) begin
					res_status_q <= STATUS_DONE;
					res_pos_q    <= pos_ext[POS_W-1:0];
				end else if (cnt_q == LAST_IDX) begin
					res_status_q <= (func_q == FUNC_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
					res_pos_q    <= '0;
				end else begin
					addr_q <= alu_y;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_pos_q    <= res_pos_q;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.position = rsp_pos_q;

endmodule
